// ===== rtl/ffa_pkg.sv =====
// Types, constants and codes shared by the first-fit heap allocator modules.
package ffa_pkg;

   localparam int HEAP_UNITS = 4096;
   localparam int ADDR_W = 12;
   localparam int LINK_W = 13;
   localparam int NEED_W = 14;
   localparam int BYTES_W = 16;

   localparam logic [LINK_W-1:0] END_CODE = LINK_W'(HEAP_UNITS);
   localparam logic [LINK_W-1:0] STEP_MAX = LINK_W'(HEAP_UNITS);
   localparam logic [LINK_W-1:0] HEAP_MIN = LINK_W'(2);

   localparam logic [1:0] STATUS_OK = 2'd0;
   localparam logic [1:0] STATUS_OOM = 2'd1;
   localparam logic [1:0] STATUS_ZERO = 2'd2;

   localparam logic MODE_ALLOC = 1'b0;

   typedef struct packed {
      logic mode;
      logic [BYTES_W-1:0] request_bytes;
      logic [ADDR_W-1:0] release_addr;
   } ffa_req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] block_addr;
      logic [1:0] status;
      logic [LINK_W-1:0] free_units;
      logic [LINK_W-1:0] min_free_units;
   } ffa_rsp_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_DECODE,
      ST_A_ISSUE,
      ST_A_EVAL,
      ST_A_SPLIT2,
      ST_F_RDF,
      ST_F_GOTF,
      ST_F_FRONT2,
      ST_F_ISSUE,
      ST_F_EVAL,
      ST_F_GROW2,
      ST_F_TAIL,
      ST_RESP
   } ffa_state_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_INIT,
      OP_CSR,
      OP_LATCH,
      OP_ZERO,
      OP_OOM,
      OP_RD_CUR,
      OP_NEXT,
      OP_A_UNLINK,
      OP_A_SPLIT1,
      OP_A_SPLIT2,
      OP_RD_F,
      OP_F_EMPTY,
      OP_F_FRONT,
      OP_F_SAVE,
      OP_F_FRONT2,
      OP_F_LINKPREV,
      OP_F_JOIN,
      OP_F_GROW,
      OP_F_MERGE_UP
   } ffa_op_type;

   typedef struct packed {
      logic mode;
      logic bytes_zero;
      logic bad_free;
      logic a_walk_done;
      logic fits;
      logic exact;
      logic head_end;
      logic head_above;
      logic fwalk_go;
      logic stop_here;
      logic adjacent;
      logic g_eq;
   } ffa_status_type;

endpackage

// ===== rtl/ffa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ffa_ram #(
   parameter int WIDTH = 13,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/ffa_datapath.sv =====
// Datapath of the heap allocator: list registers, counters and the link and size memories.
module ffa_datapath import ffa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  ffa_op_type          op,
   input  logic [LINK_W-1:0]   csr_data,
   input  ffa_req_type         req_item,
   output ffa_status_type      status,
   output ffa_rsp_type         rsp_item
);

   logic [LINK_W-1:0] heap_ff, heap_in;
   logic [LINK_W-1:0] head_ff, head_in;
   logic [LINK_W-1:0] left_ff, left_in;
   logic [LINK_W-1:0] low_ff, low_in;
   logic [LINK_W-1:0] cur_ff, cur_in;
   logic [LINK_W-1:0] prev_ff, prev_in;
   logic [LINK_W-1:0] steps_ff, steps_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [ADDR_W-1:0] f_ff, f_in;
   logic [LINK_W-1:0] s_ff, s_in;
   logic [LINK_W-1:0] rl_ff, rl_in;
   logic [LINK_W-1:0] nsz_ff, nsz_in;
   logic [NEED_W-1:0] blk_ff, blk_in;
   logic [ADDR_W-1:0] addr_out_ff, addr_out_in;
   logic [1:0]        code_ff, code_in;
   logic              mode_ff, mode_in;
   logic              zero_ff, zero_in;
   logic              bad_ff, bad_in;
   logic              oob_ff, oob_in;

   logic [LINK_W-1:0] sz_q, lk_q, q_sz, q_lk;
   logic [NEED_W-1:0] cur_plus_q, f_plus_s, g_addr, rd_addr, sz_wa, lk_wa;
   logic [LINK_W-1:0] grow_sz, taken_left, add_amt, sz_wd, lk_wd, heap_sat;
   logic [NEED_W-1:0] sum_left;
   logic [LINK_W-1:0] added_left;
   logic [BYTES_W:0]  bytes_round;
   logic              merge_f, sz_we, lk_we;

   assign q_sz = oob_ff ? '0 : sz_q;
   assign q_lk = oob_ff ? END_CODE : lk_q;
   assign cur_plus_q = {1'b0, cur_ff} + {1'b0, q_sz};
   assign f_plus_s = {2'b00, f_ff} + {1'b0, s_ff};
   assign g_addr = {1'b0, cur_ff} + {1'b0, nsz_ff};
   assign grow_sz = q_sz + s_ff;
   assign taken_left = ({1'b0, left_ff} >= need_ff) ? (left_ff - need_ff[LINK_W-1:0]) : '0;
   assign add_amt = (op == OP_F_EMPTY) ? q_sz : s_ff;
   assign sum_left = {1'b0, left_ff} + {1'b0, add_amt};
   assign added_left = sum_left[NEED_W-1] ? '1 : sum_left[LINK_W-1:0];
   assign merge_f = (f_plus_s == {1'b0, cur_ff});
   assign bytes_round = {1'b0, req_item.request_bytes} + (BYTES_W+1)'(7);
   assign heap_sat = (csr_data < HEAP_MIN) ? HEAP_MIN :
                     (csr_data > END_CODE) ? END_CODE : csr_data;

   always_comb begin
      case (op)
         OP_RD_F:     rd_addr = {2'b00, f_ff};
         OP_F_FRONT:  rd_addr = {1'b0, head_ff};
         OP_F_GROW:   rd_addr = {1'b0, cur_ff} + {1'b0, grow_sz};
         default:     rd_addr = {1'b0, cur_ff};
      endcase
   end
   assign oob_in = (rd_addr[NEED_W-1:ADDR_W] != '0);

   always_comb begin
      sz_we = 1'b0;
      sz_wa = {1'b0, cur_ff};
      sz_wd = '0;
      lk_we = 1'b0;
      lk_wa = {2'b00, f_ff};
      lk_wd = END_CODE;
      case (op)
         OP_INIT: begin
            sz_we = 1'b1;
            sz_wa = '0;
            sz_wd = heap_ff;
            lk_we = 1'b1;
            lk_wa = '0;
         end
         OP_A_UNLINK: begin
            lk_we = (prev_ff != END_CODE);
            lk_wa = {1'b0, prev_ff};
            lk_wd = q_lk;
         end
         OP_A_SPLIT1: begin
            sz_we = 1'b1;
            sz_wd = q_sz - need_ff[LINK_W-1:0];
         end
         OP_A_SPLIT2: begin
            sz_we = 1'b1;
            sz_wa = blk_ff;
            sz_wd = need_ff[LINK_W-1:0];
         end
         OP_F_EMPTY: begin
            lk_we = 1'b1;
         end
         OP_F_FRONT2, OP_F_JOIN: begin
            sz_we = merge_f;
            sz_wa = {2'b00, f_ff};
            sz_wd = s_ff + q_sz;
            lk_we = 1'b1;
            lk_wd = merge_f ? q_lk : cur_ff;
         end
         OP_F_LINKPREV: begin
            lk_we = 1'b1;
            lk_wa = {1'b0, prev_ff};
            lk_wd = {1'b0, f_ff};
         end
         OP_F_GROW: begin
            sz_we = 1'b1;
            sz_wd = grow_sz;
         end
         OP_F_MERGE_UP: begin
            sz_we = 1'b1;
            sz_wd = nsz_ff + q_sz;
            lk_we = 1'b1;
            lk_wa = {1'b0, cur_ff};
            lk_wd = q_lk;
         end
         default: begin
         end
      endcase
   end

   ffa_ram #(.WIDTH(LINK_W), .DEPTH(HEAP_UNITS)) u_size_ram (
      .clock   (clock),
      .wr_en   (sz_we && (sz_wa[NEED_W-1:ADDR_W] == '0)),
      .wr_addr (sz_wa[ADDR_W-1:0]),
      .wr_data (sz_wd),
      .rd_addr (rd_addr[ADDR_W-1:0]),
      .rd_data (sz_q)
   );

   ffa_ram #(.WIDTH(LINK_W), .DEPTH(HEAP_UNITS)) u_link_ram (
      .clock   (clock),
      .wr_en   (lk_we && (lk_wa[NEED_W-1:ADDR_W] == '0)),
      .wr_addr (lk_wa[ADDR_W-1:0]),
      .wr_data (lk_wd),
      .rd_addr (rd_addr[ADDR_W-1:0]),
      .rd_data (lk_q)
   );

   always_comb begin
      heap_in = heap_ff;
      head_in = head_ff;
      left_in = left_ff;
      low_in = low_ff;
      cur_in = cur_ff;
      prev_in = prev_ff;
      steps_in = steps_ff;
      need_in = need_ff;
      f_in = f_ff;
      s_in = s_ff;
      rl_in = rl_ff;
      nsz_in = nsz_ff;
      blk_in = blk_ff;
      addr_out_in = addr_out_ff;
      code_in = code_ff;
      mode_in = mode_ff;
      zero_in = zero_ff;
      bad_in = bad_ff;
      case (op)
         OP_CSR: begin
            heap_in = heap_sat;
         end
         OP_INIT: begin
            head_in = '0;
            left_in = heap_ff;
            low_in = heap_ff;
         end
         OP_LATCH: begin
            mode_in = req_item.mode;
            zero_in = (req_item.request_bytes == '0);
            bad_in = (req_item.release_addr == '0) ||
                     ({1'b0, req_item.release_addr} >= heap_ff);
            need_in = bytes_round[BYTES_W:3] + NEED_W'(1);
            f_in = req_item.release_addr - ADDR_W'(1);
            cur_in = head_ff;
            prev_in = END_CODE;
            steps_in = '0;
            addr_out_in = '0;
            code_in = STATUS_OK;
         end
         OP_ZERO: begin
            code_in = STATUS_ZERO;
         end
         OP_OOM: begin
            code_in = STATUS_OOM;
         end
         OP_NEXT: begin
            prev_in = cur_ff;
            cur_in = q_lk;
            steps_in = steps_ff + LINK_W'(1);
         end
         OP_A_UNLINK: begin
            if (prev_ff == END_CODE) begin
               head_in = q_lk;
            end
            addr_out_in = cur_ff[ADDR_W-1:0] + ADDR_W'(1);
            left_in = taken_left;
            low_in = (taken_left < low_ff) ? taken_left : low_ff;
         end
         OP_A_SPLIT1: begin
            blk_in = cur_plus_q - need_ff;
            addr_out_in = (cur_plus_q[ADDR_W-1:0] - need_ff[ADDR_W-1:0]) + ADDR_W'(1);
            left_in = taken_left;
            low_in = (taken_left < low_ff) ? taken_left : low_ff;
         end
         OP_F_EMPTY: begin
            head_in = {1'b0, f_ff};
            left_in = added_left;
         end
         OP_F_FRONT, OP_F_SAVE: begin
            s_in = q_sz;
         end
         OP_F_FRONT2: begin
            head_in = {1'b0, f_ff};
            left_in = added_left;
         end
         OP_F_JOIN: begin
            left_in = added_left;
         end
         OP_F_GROW: begin
            nsz_in = grow_sz;
            rl_in = q_lk;
            left_in = added_left;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_ff <= END_CODE;
         head_ff <= '0;
         left_ff <= END_CODE;
         low_ff <= END_CODE;
      end else begin
         heap_ff <= heap_in;
         head_ff <= head_in;
         left_ff <= left_in;
         low_ff <= low_in;
      end
      cur_ff <= cur_in;
      prev_ff <= prev_in;
      steps_ff <= steps_in;
      need_ff <= need_in;
      f_ff <= f_in;
      s_ff <= s_in;
      rl_ff <= rl_in;
      nsz_ff <= nsz_in;
      blk_ff <= blk_in;
      addr_out_ff <= addr_out_in;
      code_ff <= code_in;
      mode_ff <= mode_in;
      zero_ff <= zero_in;
      bad_ff <= bad_in;
      oob_ff <= oob_in;
   end

   assign status.mode = mode_ff;
   assign status.bytes_zero = zero_ff;
   assign status.bad_free = bad_ff;
   assign status.a_walk_done = cur_ff[LINK_W-1] || (steps_ff > STEP_MAX);
   assign status.fits = ({1'b0, q_sz} >= need_ff);
   assign status.exact = ({1'b0, q_sz} == need_ff);
   assign status.head_end = head_ff[LINK_W-1];
   assign status.head_above = (head_ff > {1'b0, f_ff});
   assign status.fwalk_go = !cur_ff[LINK_W-1] && (cur_ff < {1'b0, f_ff}) &&
                            (steps_ff <= STEP_MAX);
   assign status.stop_here = (cur_ff == {1'b0, f_ff}) || (prev_ff == END_CODE);
   assign status.adjacent = (cur_plus_q == {2'b00, f_ff});
   assign status.g_eq = (g_addr == {1'b0, rl_ff});

   assign rsp_item.block_addr = addr_out_ff;
   assign rsp_item.status = code_ff;
   assign rsp_item.free_units = left_ff;
   assign rsp_item.min_free_units = low_ff;

endmodule

// ===== rtl/ffa_controller.sv =====
// Controller state machine that sequences allocate, free and rebuild operations.
module ffa_controller import ffa_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic           csr_valid,
   input  ffa_status_type status,
   output ffa_op_type     op,
   output logic           busy,
   output logic           csr_ready,
   output logic           rsp_valid
);

   ffa_state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: state_in = ST_IDLE;
         ST_IDLE: begin
            if (start) begin
               state_in = ST_DECODE;
            end else if (csr_valid) begin
               state_in = ST_INIT;
            end
         end
         ST_DECODE: begin
            if (status.mode == MODE_ALLOC) begin
               state_in = status.bytes_zero ? ST_RESP : ST_A_ISSUE;
            end else begin
               state_in = status.bad_free ? ST_RESP : ST_F_RDF;
            end
         end
         ST_A_ISSUE: state_in = status.a_walk_done ? ST_RESP : ST_A_EVAL;
         ST_A_EVAL: begin
            if (!status.fits) begin
               state_in = ST_A_ISSUE;
            end else if (status.exact) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_A_SPLIT2;
            end
         end
         ST_A_SPLIT2: state_in = ST_RESP;
         ST_F_RDF: state_in = ST_F_GOTF;
         ST_F_GOTF: begin
            if (status.head_end) begin
               state_in = ST_RESP;
            end else if (status.head_above) begin
               state_in = ST_F_FRONT2;
            end else begin
               state_in = ST_F_ISSUE;
            end
         end
         ST_F_FRONT2: state_in = ST_RESP;
         ST_F_ISSUE: begin
            if (status.fwalk_go) begin
               state_in = ST_F_EVAL;
            end else if (status.stop_here) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_F_TAIL;
            end
         end
         ST_F_EVAL: state_in = status.adjacent ? ST_F_GROW2 : ST_F_ISSUE;
         ST_F_GROW2: state_in = ST_RESP;
         ST_F_TAIL: state_in = ST_RESP;
         ST_RESP: state_in = ST_IDLE;
         default: state_in = ST_INIT;
      endcase
   end

   always_comb begin
      op = OP_NONE;
      busy = 1'b1;
      csr_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_INIT: op = OP_INIT;
         ST_IDLE: begin
            busy = 1'b0;
            csr_ready = !start;
            if (start) begin
               op = OP_LATCH;
            end else if (csr_valid) begin
               op = OP_CSR;
            end
         end
         ST_DECODE: begin
            if (status.mode == MODE_ALLOC) begin
               op = status.bytes_zero ? OP_ZERO : OP_NONE;
            end else begin
               op = status.bad_free ? OP_NONE : OP_RD_F;
            end
         end
         ST_A_ISSUE: op = status.a_walk_done ? OP_OOM : OP_RD_CUR;
         ST_A_EVAL: begin
            if (!status.fits) begin
               op = OP_NEXT;
            end else if (status.exact) begin
               op = OP_A_UNLINK;
            end else begin
               op = OP_A_SPLIT1;
            end
         end
         ST_A_SPLIT2: op = OP_A_SPLIT2;
         ST_F_RDF: op = OP_RD_F;
         ST_F_GOTF: begin
            if (status.head_end) begin
               op = OP_F_EMPTY;
            end else if (status.head_above) begin
               op = OP_F_FRONT;
            end else begin
               op = OP_F_SAVE;
            end
         end
         ST_F_FRONT2: op = OP_F_FRONT2;
         ST_F_ISSUE: begin
            if (status.fwalk_go) begin
               op = OP_RD_CUR;
            end else if (!status.stop_here) begin
               op = OP_F_LINKPREV;
            end
         end
         ST_F_EVAL: op = status.adjacent ? OP_F_GROW : OP_NEXT;
         ST_F_GROW2: op = status.g_eq ? OP_F_MERGE_UP : OP_NONE;
         ST_F_TAIL: op = OP_F_JOIN;
         ST_RESP: rsp_valid = 1'b1;
         default: op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/first_fit_heap_allocator_top.sv =====
// Top level of the first-fit heap allocator with an address-ordered free list.
//
//  channel   ports                          direction  handshake
//  request   start, busy, req_item          in         start high while busy low
//  result    rsp_valid, rsp_item            out        one-cycle strobe, no stall
//  config    csr_valid, csr_ready, csr_data in         valid and ready both high
//
// An allocate walks the free list from the head until a block fits, and a free on a
// non-empty list walks it up to the place of the freed block; each free block walked
// costs one registered read of the link and size memories.
// After reset and after each heap size beat the list is rebuilt in the ST_INIT state.
// The result beat is driven from the ST_RESP state, which follows the last working state, and cannot be stalled.
module first_fit_heap_allocator_top import ffa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ffa_req_type       req_item,
   output logic              rsp_valid,
   output ffa_rsp_type       rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [LINK_W-1:0] csr_data
);

   ffa_op_type     op;
   ffa_status_type status;

   ffa_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .csr_valid (csr_valid),
      .status    (status),
      .op        (op),
      .busy      (busy),
      .csr_ready (csr_ready),
      .rsp_valid (rsp_valid)
   );

   ffa_datapath u_dp (
      .clock    (clock),
      .reset    (reset),
      .op       (op),
      .csr_data (csr_data),
      .req_item (req_item),
      .status   (status),
      .rsp_item (rsp_item)
   );

endmodule

// ===== rtl/ffa_checker.sv =====
// Port-level checker for the heap allocator and its bind to the top level.
module ffa_checker import ffa_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input ffa_req_type       req_item,
   input logic              rsp_valid,
   input ffa_rsp_type       rsp_item,
   input logic              csr_valid,
   input logic              csr_ready,
   input logic [LINK_W-1:0] csr_data
);

   a_one_cycle_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe lasted more than one cycle");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request beat accepted without going busy");

   a_busy_after_csr: assert property (@(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> busy)
      else $error("heap size beat did not trigger a rebuild");

   a_failed_addr_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.status != STATUS_OK) |-> (rsp_item.block_addr == '0))
      else $error("failed request returned a nonzero address");

   a_low_water: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.min_free_units <= rsp_item.free_units))
      else $error("low-water mark above free unit count");

endmodule

bind first_fit_heap_allocator_top ffa_checker u_ffa_checker (.*);
